[design/rwl_pkg.sv]
`default_nettype none

package rwl_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;
  localparam int TID_W              = 8;
  localparam int OP_W               = 2;
  localparam int RES_W              = 3;
  localparam int READERS_W          = 8;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_UNLOCK = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [RES_W-1:0] {
    RES_GRANTED    = 3'd0,
    RES_QUEUED     = 3'd1,
    RES_RELEASED   = 3'd2,
    RES_NOT_HOLDER = 3'd3,
    RES_QUEUE_FULL = 3'd4
  } res_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WAKE = 1'b1
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [TID_W-1:0] tid;
  } cmd_t;

  typedef struct packed {
    logic             is_write;
    logic [TID_W-1:0] tid;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wdata;
  } q_ctl_t;

  typedef struct packed {
    logic                 writer_held;
    logic [READERS_W-1:0] readers;
    logic                 in_wake;
  } lock_status_t;

endpackage

`default_nettype wire

[design/rwl_front.sv]
`default_nettype none

module rwl_front #(
  parameter int THREAD_ID_BITS = rwl_pkg::THREAD_ID_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rwl_pkg::OP_W-1:0]    in_operation,
  input  wire logic [rwl_pkg::TID_W-1:0]   in_thread_id,
  output logic                             cmd_valid,
  output rwl_pkg::cmd_t                    cmd,
  input  wire logic                        cmd_pop
);

  localparam logic [rwl_pkg::TID_W-1:0] TID_MASK =
    (THREAD_ID_BITS >= rwl_pkg::TID_W) ? {rwl_pkg::TID_W{1'b1}}
                                       : rwl_pkg::TID_W'((1 << THREAD_ID_BITS) - 1);

  rwl_pkg::op_t  op_in;
  rwl_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;

  assign op_in     = rwl_pkg::op_t'(in_operation);
  assign in_ready  = (cnt_r != 2'd2);
  // An unknown operation is taken and dropped here, so it never reaches the back end.
  assign push      = in_valid && in_ready && (op_in != rwl_pkg::OP_NONE);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{op: op_in, tid: in_thread_id & TID_MASK};
    end
  end

endmodule

`default_nettype wire

[design/rwl_waitq.sv]
`default_nettype none

module rwl_waitq #(
  parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rwl_pkg::q_ctl_t q_ctl,
  output rwl_pkg::entry_t      q_head,
  output rwl_pkg::entry_t      q_next,
  output logic [CNT_W-1:0]     q_count
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  rwl_pkg::entry_t   mem [QUEUE_DEPTH];
  rwl_pkg::entry_t   head_entry_r;
  rwl_pkg::entry_t   next_entry_r;
  logic [IDX_W-1:0]  head_r, head_nxt, head_nxt2;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  always_comb begin
    head_nxt  = q_ctl.pop ? wrap_inc(head_r) : head_r;
    head_nxt2 = wrap_inc(head_nxt);
    tail_nxt  = q_ctl.push ? wrap_inc(tail_r) : tail_r;
    count_nxt = count_r;
    if (q_ctl.push && !q_ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_ctl.push && q_ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // The head and the entry behind it are read every cycle; a write to either slot is
  // forwarded so the registered copies always match the memory.
  always_ff @(posedge clk) begin
    if (q_ctl.push) begin
      mem[tail_r] <= q_ctl.wdata;
    end
    head_entry_r <= (q_ctl.push && (tail_r == head_nxt)) ? q_ctl.wdata : mem[head_nxt];
    next_entry_r <= (q_ctl.push && (tail_r == head_nxt2)) ? q_ctl.wdata : mem[head_nxt2];
  end

  assign q_head  = head_entry_r;
  assign q_next  = next_entry_r;
  assign q_count = count_r;

endmodule

`default_nettype wire

[design/rwl_back.sv]
`default_nettype none

module rwl_back #(
  parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cmd_valid,
  input  wire rwl_pkg::cmd_t               cmd,
  output logic                             cmd_pop,
  output rwl_pkg::q_ctl_t                  q_ctl,
  input  wire rwl_pkg::entry_t             q_head,
  input  wire rwl_pkg::entry_t             q_next,
  input  wire logic [CNT_W-1:0]            q_count,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rwl_pkg::RES_W-1:0]        out_event_res,
  output logic [rwl_pkg::TID_W-1:0]        out_event_thread,
  output logic                             out_event_is_write,
  output logic                             out_last,
  output rwl_pkg::lock_status_t            status
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
  localparam logic [rwl_pkg::READERS_W-1:0] READERS_MAX = '1;

  rwl_pkg::state_t                state_r, state_nxt;
  logic                           writer_held_r, writer_held_nxt;
  logic [rwl_pkg::TID_W-1:0]      writer_thread_r, writer_thread_nxt;
  logic [rwl_pkg::READERS_W-1:0]  readers_r, readers_nxt;
  logic [rwl_pkg::READERS_W-1:0]  readers_inc, readers_dec;
  logic                           out_valid_r, out_valid_nxt;
  rwl_pkg::res_t                  res_r, res_nxt;
  logic [rwl_pkg::TID_W-1:0]      thread_r, thread_nxt;
  logic                           is_write_r, is_write_nxt;
  logic                           last_r, last_nxt;
  logic                           can_emit, emit;
  logic                           wake_start, wake_end;
  logic                           wake_after_w, wake_after_r;

  assign can_emit    = !out_valid_r || out_ready;
  assign readers_inc = (readers_r == READERS_MAX) ? readers_r : readers_r + 1'b1;
  assign readers_dec = readers_r - 1'b1;

  // Whether a release leaves work for the wake-up pass, for a write or a read release.
  assign wake_after_w = (q_count != '0) &&
                        (!q_head.is_write || (readers_r == '0));
  assign wake_after_r = (q_count != '0) &&
                        (!q_head.is_write || ((readers_dec == '0) && !writer_held_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rwl_pkg::ST_IDLE: begin
        if (wake_start) begin
          state_nxt = rwl_pkg::ST_WAKE;
        end
      end
      rwl_pkg::ST_WAKE: begin
        if (wake_end) begin
          state_nxt = rwl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rwl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop           = 1'b0;
    q_ctl             = '0;
    emit              = 1'b0;
    wake_start        = 1'b0;
    wake_end          = 1'b0;
    writer_held_nxt   = writer_held_r;
    writer_thread_nxt = writer_thread_r;
    readers_nxt       = readers_r;
    res_nxt           = res_r;
    thread_nxt        = thread_r;
    is_write_nxt      = is_write_r;
    last_nxt          = last_r;
    unique case (state_r)
      rwl_pkg::ST_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_pop      = 1'b1;
          emit         = 1'b1;
          thread_nxt   = cmd.tid;
          last_nxt     = 1'b1;
          is_write_nxt = 1'b0;
          unique case (cmd.op)
            rwl_pkg::OP_READ, rwl_pkg::OP_WRITE: begin
              is_write_nxt = (cmd.op == rwl_pkg::OP_WRITE);
              if ((cmd.op == rwl_pkg::OP_READ) && !writer_held_r && (q_count == '0)) begin
                readers_nxt = readers_inc;
                res_nxt     = rwl_pkg::RES_GRANTED;
              end else if ((cmd.op == rwl_pkg::OP_WRITE) && !writer_held_r &&
                           (readers_r == '0)) begin
                writer_held_nxt   = 1'b1;
                writer_thread_nxt = cmd.tid;
                res_nxt           = rwl_pkg::RES_GRANTED;
              end else if (q_count == FULL_CNT) begin
                res_nxt = rwl_pkg::RES_QUEUE_FULL;
              end else begin
                q_ctl.push           = 1'b1;
                q_ctl.wdata.is_write = (cmd.op == rwl_pkg::OP_WRITE);
                q_ctl.wdata.tid      = cmd.tid;
                res_nxt              = rwl_pkg::RES_QUEUED;
              end
            end
            rwl_pkg::OP_UNLOCK: begin
              if (writer_held_r && (writer_thread_r == cmd.tid)) begin
                writer_held_nxt   = 1'b0;
                writer_thread_nxt = '0;
                res_nxt           = rwl_pkg::RES_RELEASED;
                is_write_nxt      = 1'b1;
                wake_start        = wake_after_w;
                last_nxt          = !wake_after_w;
              end else if (readers_r != '0) begin
                readers_nxt = readers_dec;
                res_nxt     = rwl_pkg::RES_RELEASED;
                wake_start  = wake_after_r;
                last_nxt    = !wake_after_r;
              end else begin
                res_nxt = rwl_pkg::RES_NOT_HOLDER;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      rwl_pkg::ST_WAKE: begin
        if (can_emit) begin
          emit       = 1'b1;
          q_ctl.pop  = 1'b1;
          res_nxt    = rwl_pkg::RES_GRANTED;
          thread_nxt = q_head.tid;
          if (q_head.is_write) begin
            writer_held_nxt   = 1'b1;
            writer_thread_nxt = q_head.tid;
            is_write_nxt      = 1'b1;
            wake_end          = 1'b1;
          end else begin
            readers_nxt  = readers_inc;
            is_write_nxt = 1'b0;
            wake_end     = (q_count == ONE_CNT) || q_next.is_write;
          end
          last_nxt = wake_end;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= rwl_pkg::ST_IDLE;
      writer_held_r   <= 1'b0;
      writer_thread_r <= '0;
      readers_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      writer_held_r   <= writer_held_nxt;
      writer_thread_r <= writer_thread_nxt;
      readers_r       <= readers_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    thread_r   <= thread_nxt;
    is_write_r <= is_write_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = res_r;
  assign out_event_thread   = thread_r;
  assign out_event_is_write = is_write_r;
  assign out_last           = last_r;

  assign status.writer_held = writer_held_r;
  assign status.readers     = readers_r;
  assign status.in_wake     = (state_r == rwl_pkg::ST_WAKE);

endmodule

`default_nettype wire

[design/fifo_reader_writer_lock.sv]
`default_nettype none

// Lock manager for one reader-writer lock with a FIFO of waiting requests. A front end
// takes each request, drops unknown operations and places the rest in a two-entry command
// queue; the back end executes one command at a time against the lock state and the wait
// queue, which is a memory with registered reads of its head and next entries. A read or
// write lock request presents its one result in the cycle after the back end takes it.
// An unlock produces one release or error result and then one grant per woken waiter,
// one result per cycle while the result channel does not stall, and holds the back end
// until its last grant. The single output register sets that pace, and a stalled result
// channel stalls the back end while the front end keeps taking up to two more requests.
module fifo_reader_writer_lock #(
  parameter int QUEUE_DEPTH    = rwl_pkg::QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = rwl_pkg::THREAD_ID_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [rwl_pkg::OP_W-1:0]  in_operation,
  input  wire logic [rwl_pkg::TID_W-1:0] in_thread_id,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [rwl_pkg::RES_W-1:0]      out_event_res,
  output logic [rwl_pkg::TID_W-1:0]      out_event_thread,
  output logic                           out_event_is_write,
  output logic                           out_last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                  cmd_valid;
  rwl_pkg::cmd_t         cmd;
  logic                  cmd_pop;
  rwl_pkg::q_ctl_t       q_ctl;
  rwl_pkg::entry_t       q_head;
  rwl_pkg::entry_t       q_next;
  logic [CNT_W-1:0]      q_count;
  rwl_pkg::lock_status_t status;

  rwl_front #(
    .THREAD_ID_BITS(THREAD_ID_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_thread_id(in_thread_id),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  rwl_waitq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_waitq (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_ctl  (q_ctl),
    .q_head (q_head),
    .q_next (q_next),
    .q_count(q_count)
  );

  rwl_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .q_ctl             (q_ctl),
    .q_head            (q_head),
    .q_next            (q_next),
    .q_count           (q_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_event_thread  (out_event_thread),
    .out_event_is_write(out_event_is_write),
    .out_last          (out_last),
    .status            (status)
  );

  a_writer_excludes_readers: assert property (@(posedge clk) disable iff (!rst_n)
    status.writer_held |-> (status.readers == '0))
    else $error("write lock held while read locks are counted");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("wait queue count exceeds its depth");

  a_wake_needs_waiter: assert property (@(posedge clk) disable iff (!rst_n)
    status.in_wake |-> (q_count != '0))
    else $error("wake-up pass running with an empty wait queue");

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_ctl.push && q_ctl.pop))
    else $error("wait queue pushed and popped in one cycle");

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
  import rwl_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;

  typedef struct {
    cmd_t cmd;
    bit   hold;
  } request_slot_t;

  typedef struct {
    res_t             res;
    logic [TID_W-1:0] tid;
    logic             is_write;
    logic             last;
  } lock_event_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_PATTERN,
    RX_RANDOM
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = OP_NONE;
  logic [TID_W-1:0] in_thread_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RES_W-1:0] out_event_res;
  logic [TID_W-1:0] out_event_thread;
  logic out_event_is_write;
  logic out_last;

  request_slot_t pending_requests[$];
  lock_event_t expected_events[$];
  int err_cnt = 0;

  logic writer_owned = 1'b0;
  logic [TID_W-1:0] owner_tid = '0;
  logic [READERS_W-1:0] reader_cnt = '0;
  entry_t waiters [QDEPTH];
  int unsigned wq_head = 0;
  int unsigned wq_tail = 0;
  int unsigned wq_count = 0;

  fifo_reader_writer_lock DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_thread_id       (in_thread_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_event_thread   (out_event_thread),
    .out_event_is_write (out_event_is_write),
    .out_last           (out_last)
  );

  always #5 clk = ~clk;

  task automatic add_request(op_t op, logic [TID_W-1:0] tid, bit hold = 1'b0);
    request_slot_t s;
    s.cmd.op = op;
    s.cmd.tid = tid;
    s.hold = hold;
    pending_requests.push_back(s);
  endtask

  task automatic post_event(res_t res, logic [TID_W-1:0] tid, logic is_write);
    lock_event_t ev;
    ev.res = res;
    ev.tid = tid;
    ev.is_write = is_write;
    ev.last = 1'b0;
    expected_events.push_back(ev);
  endtask

  function automatic void bump_readers();
    if (reader_cnt != '1) begin
      reader_cnt++;
    end
  endfunction

  function automatic entry_t pop_waiter();
    entry_t e;
    e = waiters[wq_head];
    wq_head = (wq_head + 1) % QDEPTH;
    wq_count--;
    return e;
  endfunction

  task automatic enqueue_waiter(logic [TID_W-1:0] tid, logic is_write);
    if (wq_count >= QDEPTH) begin
      post_event(RES_QUEUE_FULL, tid, is_write);
    end else begin
      waiters[wq_tail].is_write = is_write;
      waiters[wq_tail].tid = tid;
      wq_tail = (wq_tail + 1) % QDEPTH;
      wq_count++;
      post_event(RES_QUEUED, tid, is_write);
    end
  endtask

  task automatic wake_waiters();
    entry_t e;
    if (wq_count != 0) begin
      if (waiters[wq_head].is_write) begin
        if (reader_cnt == 0 && !writer_owned) begin
          e = pop_waiter();
          writer_owned = 1'b1;
          owner_tid = e.tid;
          post_event(RES_GRANTED, e.tid, 1'b1);
        end
      end else begin
        while (wq_count != 0 && !waiters[wq_head].is_write) begin
          e = pop_waiter();
          bump_readers();
          post_event(RES_GRANTED, e.tid, 1'b0);
        end
      end
    end
  endtask

  task automatic apply_request(op_t op, logic [TID_W-1:0] tid);
    int unsigned n0;
    n0 = expected_events.size();
    case (op)
      OP_READ: begin
        if (!writer_owned && wq_count == 0) begin
          bump_readers();
          post_event(RES_GRANTED, tid, 1'b0);
        end else begin
          enqueue_waiter(tid, 1'b0);
        end
      end
      OP_WRITE: begin
        if (reader_cnt == 0 && !writer_owned) begin
          writer_owned = 1'b1;
          owner_tid = tid;
          post_event(RES_GRANTED, tid, 1'b1);
        end else begin
          enqueue_waiter(tid, 1'b1);
        end
      end
      OP_UNLOCK: begin
        if (writer_owned && owner_tid == tid) begin
          writer_owned = 1'b0;
          owner_tid = '0;
          post_event(RES_RELEASED, tid, 1'b1);
          wake_waiters();
        end else if (reader_cnt != 0) begin
          reader_cnt--;
          post_event(RES_RELEASED, tid, 1'b0);
          wake_waiters();
        end else begin
          post_event(RES_NOT_HOLDER, tid, 1'b0);
        end
      end
      default: begin
      end
    endcase
    if (expected_events.size() > n0) begin
      expected_events[expected_events.size() - 1].last = 1'b1;
    end
  endtask

  task automatic compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      err_cnt++;
    end
  endtask

  int burst_left = 1;
  int gap_left = 0;

  // A request marked hold is not offered until every earlier result has come back.
  always @(posedge clk) begin
    request_slot_t nxt;
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].hold &&
                    (in_valid || expected_events.size() != 0))) begin
        in_valid <= 1'b0;
      end else begin
        nxt = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_operation <= nxt.cmd.op;
        in_thread_id <= nxt.cmd.tid;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  logic [5:0] stall_phase = '0;
  rx_mode_t stall_mode = RX_OPEN;
  logic [15:0] stall_bits = '1;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 2));
      stall_bits <= 16'($urandom);
    end
    case (stall_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_PATTERN: out_ready <= stall_bits[stall_phase[3:0]];
      default:    out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    lock_event_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_request(op_t'(in_operation), in_thread_id);
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: res %0d thread %0d", out_event_res, out_event_thread);
          err_cnt++;
        end else begin
          want = expected_events.pop_front();
          compare_field("event_res", want.res, out_event_res);
          compare_field("event_thread", want.tid, out_event_thread);
          compare_field("event_is_write", want.is_write, out_event_is_write);
          compare_field("last", want.last, out_last);
        end
      end
    end
  end

  initial begin
    op_t op;
    int pick;
    logic [TID_W-1:0] tid;
    logic [TID_W-1:0] recent_writers [4];
    int wr_slot;

    add_request(OP_UNLOCK, 8'h00);
    add_request(OP_NONE, 8'hFF);
    add_request(OP_READ, 8'hFF);
    add_request(OP_READ, 8'h01);
    add_request(OP_WRITE, 8'h00);
    add_request(OP_READ, 8'h55);
    add_request(OP_UNLOCK, 8'hAA);
    add_request(OP_UNLOCK, 8'h02);
    add_request(OP_READ, 8'h33);
    add_request(OP_UNLOCK, 8'h55);
    add_request(OP_UNLOCK, 8'h00);
    add_request(OP_UNLOCK, 8'h55);
    add_request(OP_UNLOCK, 8'h33);
    add_request(OP_WRITE, 8'h80);
    for (int i = 0; i < QDEPTH; i++) begin
      add_request(OP_READ, {4'(i), ~4'(i)});
    end
    add_request(OP_READ, 8'h7F);
    add_request(OP_WRITE, 8'h3C);
    add_request(OP_UNLOCK, 8'h80);

    for (int i = 0; i < 4; i++) begin
      recent_writers[i] = 8'($urandom);
    end
    wr_slot = 0;
    for (int k = 0; k < 120; k++) begin
      pick = $urandom_range(0, 99);
      tid = 8'($urandom);
      if (pick < 40) begin
        op = OP_READ;
      end else if (pick < 65) begin
        op = OP_WRITE;
        if ($urandom_range(0, 1) == 0) begin
          tid = recent_writers[$urandom_range(0, 3)];
        end
        recent_writers[wr_slot] = tid;
        wr_slot = (wr_slot + 1) % 4;
      end else if (pick < 97) begin
        op = OP_UNLOCK;
        if ($urandom_range(0, 1) == 0) begin
          tid = recent_writers[$urandom_range(0, 3)];
        end
      end else begin
        op = OP_NONE;
      end
      add_request(op, tid, k == 60);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_events.size() == 0 && err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
